// ----- hdl/cfbd_pkg.sv -----
package cfbd_pkg;

    localparam int BASE_ID_BITS = 11;
    localparam int EXT_ID_BITS  = 18;
    localparam int CRC_BITS     = 15;
    localparam int EOF_BITS     = 7;
    localparam int DLC_BITS     = 4;
    localparam int ID_BITS      = BASE_ID_BITS + EXT_ID_BITS;
    localparam int PAYLOAD_BITS = 64;
    localparam int CNT_BITS     = 7;

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_ID_A      = 5'd1;
    localparam logic [4:0] PH_RTR_SRR   = 5'd2;
    localparam logic [4:0] PH_IDE       = 5'd3;
    localparam logic [4:0] PH_ID_B      = 5'd4;
    localparam logic [4:0] PH_RTR_EXT   = 5'd5;
    localparam logic [4:0] PH_R1        = 5'd6;
    localparam logic [4:0] PH_R0        = 5'd7;
    localparam logic [4:0] PH_STANDBY   = 5'd8;
    localparam logic [4:0] PH_DLC       = 5'd9;
    localparam logic [4:0] PH_DATA      = 5'd10;
    localparam logic [4:0] PH_CRC       = 5'd11;
    localparam logic [4:0] PH_CRC_DELIM = 5'd12;
    localparam logic [4:0] PH_ACK_SLOT  = 5'd13;
    localparam logic [4:0] PH_ACK_DELIM = 5'd14;
    localparam logic [4:0] PH_EOF       = 5'd15;
    localparam logic [4:0] PH_ERROR     = 5'd16;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_STUFF  = 2'd1;
    localparam logic [1:0] ERR_FORMAT = 2'd2;
    localparam logic [1:0] ERR_CRC    = 2'd3;

    typedef struct packed {
        logic                    bit_value;
        logic                    stuff_violation;
        logic                    arbitration_lost;
        logic [CRC_BITS-1:0]     computed_crc;
        logic                    computed_crc_ready;
    } in_item_t;

    typedef struct packed {
        logic                    frame_done;
        logic [ID_BITS-1:0]      frame_ident;
        logic                    extended_format;
        logic                    remote_request;
        logic [DLC_BITS-1:0]     data_length;
        logic [PAYLOAD_BITS-1:0] payload_bits;
        logic [1:0]              error_code;
        logic                    ack_drive;
        logic                    ack_slot_active;
        logic                    destuff_enable;
        logic                    crc_request;
        logic                    bus_idle;
    } out_item_t;

    typedef struct packed {
        logic [4:0]              field_phase;
        logic [CNT_BITS-1:0]     bit_counter;
        logic [ID_BITS-1:0]      ident_shift;
        logic                    remote_flag;
        logic                    extended_flag;
        logic [DLC_BITS-1:0]     length_shift;
        logic [PAYLOAD_BITS-1:0] payload_shift;
        logic [CRC_BITS-1:0]     received_crc;
        logic                    lost_flag;
        logic                    ack_level;
        logic [1:0]              sticky_error;
    } dec_state_t;

endpackage

// ----- hdl/cfbd_intf.sv -----
interface cfbd_in_if
    import cfbd_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cfbd_out_if
    import cfbd_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/cfbd_step.sv -----
module cfbd_step
    import cfbd_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
)
(
    input  dec_state_t cur,
    input  in_item_t   item,
    output dec_state_t nxt,
    output out_item_t  res
);

    localparam logic [DLC_BITS-1:0] MAX_LEN = DLC_BITS'(MAX_DATA_BYTES);

    logic                b;
    logic                done;
    logic [CNT_BITS-1:0] cnt_inc;
    logic [DLC_BITS-1:0] len_new;
    logic [DLC_BITS-1:0] len_clamped;

    assign b           = item.bit_value;
    assign cnt_inc     = cur.bit_counter + CNT_BITS'(1);
    assign len_new     = {cur.length_shift[DLC_BITS-2:0], b};
    assign len_clamped = (len_new > MAX_LEN) ? MAX_LEN : len_new;

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        if (cur.field_phase != PH_ERROR && item.stuff_violation)
        begin
            nxt.sticky_error = ERR_STUFF;
            nxt.field_phase  = PH_ERROR;
            nxt.ack_level    = 1'b1;
        end
        else
        begin
            unique case (cur.field_phase)
                PH_IDLE:
                begin
                    nxt.lost_flag = 1'b0;
                    if (!b)
                    begin
                        nxt.received_crc = '0;
                        nxt.bit_counter  = '0;
                        nxt.ident_shift  = '0;
                        nxt.lost_flag    = item.arbitration_lost;
                        nxt.field_phase  = PH_ID_A;
                    end
                end
                PH_ID_A, PH_ID_B:
                begin
                    nxt.ident_shift = {cur.ident_shift[ID_BITS-2:0], b};
                    nxt.bit_counter = cnt_inc;
                    nxt.lost_flag   = cur.lost_flag | item.arbitration_lost;
                    if (cur.field_phase == PH_ID_A && cnt_inc == CNT_BITS'(BASE_ID_BITS))
                        nxt.field_phase = PH_RTR_SRR;
                    else if (cur.field_phase == PH_ID_B
                             && cnt_inc == CNT_BITS'(EXT_ID_BITS))
                        nxt.field_phase = PH_RTR_EXT;
                end
                PH_RTR_SRR:
                begin
                    nxt.remote_flag = b;
                    nxt.lost_flag   = cur.lost_flag | item.arbitration_lost;
                    nxt.field_phase = PH_IDE;
                end
                PH_IDE:
                begin
                    nxt.extended_flag = b;
                    nxt.lost_flag     = cur.lost_flag | item.arbitration_lost;
                    nxt.bit_counter   = '0;
                    nxt.field_phase   = b ? PH_ID_B : PH_R0;
                end
                PH_RTR_EXT:
                begin
                    if (!cur.remote_flag)
                    begin
                        nxt.sticky_error = ERR_FORMAT;
                        nxt.field_phase  = PH_ERROR;
                        nxt.ack_level    = 1'b1;
                    end
                    else
                    begin
                        nxt.remote_flag = b;
                        nxt.lost_flag   = cur.lost_flag | item.arbitration_lost;
                        nxt.field_phase = PH_R1;
                    end
                end
                PH_R1:
                    nxt.field_phase = PH_R0;
                PH_R0:
                begin
                    nxt.length_shift = '0;
                    nxt.bit_counter  = '0;
                    nxt.field_phase  = cur.lost_flag ? PH_STANDBY : PH_DLC;
                end
                PH_STANDBY:
                    nxt.field_phase = PH_IDLE;
                PH_DLC:
                begin
                    nxt.length_shift = len_new;
                    nxt.bit_counter  = cnt_inc;
                    if (cnt_inc == CNT_BITS'(DLC_BITS))
                    begin
                        nxt.length_shift  = len_clamped;
                        nxt.received_crc  = '0;
                        nxt.payload_shift = '0;
                        nxt.bit_counter   = '0;
                        if (!cur.remote_flag && len_clamped != '0)
                            nxt.field_phase = PH_DATA;
                        else
                            nxt.field_phase = PH_CRC;
                    end
                end
                PH_DATA:
                begin
                    nxt.payload_shift = {cur.payload_shift[PAYLOAD_BITS-2:0], b};
                    nxt.bit_counter   = cnt_inc;
                    if (cnt_inc == {cur.length_shift, 3'b000})
                    begin
                        nxt.bit_counter = '0;
                        nxt.field_phase = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    nxt.received_crc = {cur.received_crc[CRC_BITS-2:0], b};
                    nxt.bit_counter  = cnt_inc;
                    if (cnt_inc == CNT_BITS'(CRC_BITS))
                        nxt.field_phase = PH_CRC_DELIM;
                end
                PH_CRC_DELIM:
                begin
                    if (item.computed_crc_ready)
                    begin
                        nxt.ack_level   = (cur.received_crc == item.computed_crc) ? 1'b0 : 1'b1;
                        nxt.field_phase = PH_ACK_SLOT;
                    end
                end
                PH_ACK_SLOT:
                    nxt.field_phase = PH_ACK_DELIM;
                PH_ACK_DELIM:
                begin
                    nxt.ack_level = 1'b1;
                    if (cur.ack_level)
                    begin
                        nxt.sticky_error = ERR_CRC;
                        nxt.field_phase  = PH_ERROR;
                    end
                    else if (!b)
                    begin
                        nxt.sticky_error = ERR_FORMAT;
                        nxt.field_phase  = PH_ERROR;
                    end
                    else
                    begin
                        nxt.bit_counter = '0;
                        nxt.field_phase = PH_EOF;
                    end
                end
                PH_EOF:
                begin
                    nxt.bit_counter = cnt_inc;
                    if (!b)
                    begin
                        nxt.sticky_error = ERR_FORMAT;
                        nxt.field_phase  = PH_ERROR;
                        nxt.ack_level    = 1'b1;
                    end
                    else if (cnt_inc >= CNT_BITS'(EOF_BITS))
                    begin
                        done            = 1'b1;
                        nxt.field_phase = PH_IDLE;
                    end
                end
                default:
                    nxt.field_phase = PH_ERROR;
            endcase
        end
    end

    always_comb
    begin
        res.frame_done      = done;
        res.frame_ident     = nxt.ident_shift;
        res.extended_format = nxt.extended_flag;
        res.remote_request  = nxt.remote_flag;
        res.data_length     = nxt.length_shift;
        res.payload_bits    = nxt.payload_shift;
        res.error_code      = nxt.sticky_error;
        res.ack_drive       = nxt.ack_level;
        res.ack_slot_active = (nxt.field_phase == PH_ACK_SLOT)
                              || (nxt.field_phase == PH_ACK_DELIM);
        res.destuff_enable  = (nxt.field_phase >= PH_ID_A) && (nxt.field_phase <= PH_CRC)
                              && (nxt.field_phase != PH_STANDBY);
        res.crc_request     = (nxt.field_phase == PH_CRC)
                              || (nxt.field_phase == PH_CRC_DELIM);
        res.bus_idle        = (nxt.field_phase == PH_IDLE);
    end

endmodule

// ----- hdl/can_frame_bit_decoder_unit.sv -----
// Receive-side CAN 2.0B frame decoder taking one destuffed bus bit per request and
// returning exactly one result per request. Each accepted bit is decoded in the cycle
// it arrives and its result appears on the next cycle from an output register, so the
// block sustains one bit per clock; it stalls only while that output register holds a
// result the sink has not yet taken. Stuff, format and CRC errors are sticky until reset.
module can_frame_bit_decoder_unit
    import cfbd_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    cfbd_in_if.sink    rx,
    cfbd_out_if.source result
);

    localparam dec_state_t STATE_RESET = '{
        field_phase:   PH_IDLE,
        bit_counter:   '0,
        ident_shift:   '0,
        remote_flag:   1'b0,
        extended_flag: 1'b0,
        length_shift:  '0,
        payload_shift: '0,
        received_crc:  '0,
        lost_flag:     1'b0,
        ack_level:     1'b1,
        sticky_error:  ERR_NONE
    };

    dec_state_t state_reg;
    dec_state_t state_next;
    out_item_t  res_reg;
    out_item_t  res_next;
    logic       res_valid_reg;
    logic       accept;

    assign rx.ready     = !res_valid_reg || result.ready;
    assign accept       = rx.valid && rx.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    cfbd_step #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_step (
        .cur  (state_reg),
        .item (rx.data),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

endmodule
